[design/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator: item kinds, sequencer
// states, merge unit operations and the tree memory control word.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// Width of the byte fields on the item ports
	localparam int unsigned FIELD_W = 12;

	// Item kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DESC,
		ST_TGT,
		ST_CLIMB,
		ST_UP,
		ST_DONE
	} state_t;

	// Node update operations of the shared unit
	typedef enum logic {
		ALU_MAX,
		ALU_MERGE
	} alu_op_t;

	// Tree memory port control
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

[design/buddy_page_allocator_unit.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy allocator for one page with a header. Walks a longest-free tree one
// node per cycle under a small sequencer, using one shared compare unit.
// ----------------------------------------------------------------------------
// Steps: an allocate descends to the block's depth (0..LEVELS), claims the node if
//   it fits and climbs back to the root; a free climbs from the leaf to the allocated
//   node and merges up to the root; words rejected at accept go straight to DONE.
// Flow: a new item is taken only in idle, so the input stalls for the whole walk;
//   DONE holds while the result word is stalled.
// Reset: per-node valid bits clear at once, so the tree reads its initial lengths.
module buddy_page_allocator_unit #(
	parameter int unsigned PAGE_BYTES     = 4096,
	parameter int unsigned MIN_BLOCK      = 32,
	parameter int unsigned RESERVED_BYTES = 520
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [bpa_pkg::FIELD_W-1:0]   req_size,
	input  logic [bpa_pkg::FIELD_W-1:0]   free_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic [bpa_pkg::FIELD_W-1:0]   block_offset,
	output logic                          page_empty
);

	localparam int unsigned LOG_PAGE   = $clog2(PAGE_BYTES);
	localparam int unsigned LOG_MIN    = $clog2(MIN_BLOCK);
	localparam int unsigned LEVELS     = LOG_PAGE - LOG_MIN;
	localparam int unsigned LEAF_COUNT = PAGE_BYTES / MIN_BLOCK;
	localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT - 1;
	localparam int unsigned IW         = LEVELS + 1;
	localparam int unsigned LW         = $clog2(LEVELS + 1);
	localparam int unsigned VAL_W      = LOG_PAGE + 1;
	localparam int unsigned W          = (VAL_W > bpa_pkg::FIELD_W) ? VAL_W
	                                     : bpa_pkg::FIELD_W;
	localparam int unsigned RES_W      = $clog2(RESERVED_BYTES + 1);
	localparam int unsigned GW         = ((W > RES_W) ? W : RES_W) + 1;
	localparam logic [GW-1:0]    RES_G   = GW'(RESERVED_BYTES);
	localparam logic [GW-1:0]    PAGE_G  = GW'(PAGE_BYTES);
	localparam logic [VAL_W-1:0] ROOT_USABLE = VAL_W'((PAGE_BYTES > RESERVED_BYTES)
	                                           ? (PAGE_BYTES - RESERVED_BYTES) : 0);

	// Node start byte at a level and position
	function automatic logic [GW-1:0] node_start(input logic [LW-1:0] lvl,
	                                             input logic [LEVELS-1:0] pos);
		return GW'(pos) << (LOG_PAGE - int'(lvl));
	endfunction

	// Node length less the header overlap, floored at zero
	function automatic logic [VAL_W-1:0] usable_len(input logic [LW-1:0] lvl,
	                                                input logic [LEVELS-1:0] pos);
		logic [GW-1:0] sz;
		logic [GW-1:0] start;
		logic [GW-1:0] stop;
		logic [GW-1:0] len;
		sz    = PAGE_G >> lvl;
		start = node_start(lvl, pos);
		stop  = start + sz;
		if (stop <= RES_G) begin
			len = '0;
		end else if (start < RES_G) begin
			len = stop - RES_G;
		end else begin
			len = sz;
		end
		return len[VAL_W-1:0];
	endfunction

	// Heap index of a node
	function automatic logic [IW-1:0] node_idx(input logic [LW-1:0] lvl,
	                                           input logic [LEVELS-1:0] pos);
		logic [IW-1:0] base;
		base = (IW'(1) << lvl) - IW'(1);
		return base + IW'(pos);
	endfunction

	bpa_pkg::state_t   state_q, state_d;
	bpa_pkg::mem_ctl_t mem_ctl;

	logic                        kind_q, kind_d;
	logic [W-1:0]                req_q, req_d;
	logic [LW-1:0]               tl_q, tl_d;
	logic [LW-1:0]               lvl_q, lvl_d;
	logic [LEVELS-1:0]           pos_q, pos_d;
	logic [VAL_W-1:0]            cur_q, cur_d;
	logic [VAL_W-1:0]            root_q, root_d;
	logic                        res_ok_q, res_ok_d;
	logic [bpa_pkg::FIELD_W-1:0] res_off_q, res_off_d;
	logic [LW-1:0]               rd_lvl_q, rd_lvl_d;
	logic [LEVELS-1:0]           rd_pos_q, rd_pos_d;

	logic                        out_valid_q;
	logic                        ok_q;
	logic [bpa_pkg::FIELD_W-1:0] block_offset_q;
	logic                        page_empty_q;

	logic [IW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [IW-1:0]    rd_addr;
	logic [VAL_W-1:0] mem_rd_data;
	logic             mem_rd_hit;

	logic             in_acc;
	logic             out_load;
	logic [LW-1:0]    tl_calc;
	logic             fits;
	logic [GW-1:0]    off_g;
	logic [GW-1:0]    leaf_g;
	logic [LEVELS-1:0] leaf_pos;
	logic             off_past;
	logic             alloc_go;
	logic             free_go;
	logic [VAL_W-1:0] rd_usable;
	logic [VAL_W-1:0] rd_val;
	logic             rd_zero;
	logic [LW-1:0]    geo_lvl;
	logic [LEVELS-1:0] geo_pos;
	logic [VAL_W-1:0] geo_len;
	logic [LW-1:0]    up_lvl;
	logic [LEVELS-1:0] up_pos;
	logic [LW-1:0]    dn_lvl;
	logic [LEVELS-1:0] dn_pos;
	logic [GW-1:0]    off_calc;
	logic [VAL_W-1:0] up_val;

	bpa_pkg::alu_op_t alu_op;
	logic [W-1:0]     alu_a;
	logic [W-1:0]     alu_b;
	logic [W-1:0]     alu_full;
	logic             alu_ge;
	logic [W-1:0]     alu_res;

	// Handshakes
	assign in_stall = (state_q != bpa_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == bpa_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// Round the request up to a block size and find its tree depth
	always_comb begin
		tl_calc = '0;
		fits    = 1'b0;
		for (int k = LEVELS; k >= 0; k--) begin
			if (GW'(req_size) <= (GW'(MIN_BLOCK) << k)) begin
				fits    = 1'b1;
				tl_calc = LW'(LEVELS - k);
			end
		end
	end

	// Locate the leaf of a free offset
	assign off_g    = GW'(free_offset);
	assign leaf_g   = off_g >> LOG_MIN;
	assign leaf_pos = leaf_g[LEVELS-1:0];
	assign off_past = (off_g >= PAGE_G);

	// Supply the initial length for nodes not yet written
	assign rd_usable = usable_len(rd_lvl_q, rd_pos_q);
	assign rd_val    = mem_rd_hit ? mem_rd_data : rd_usable;
	assign rd_zero   = (rd_val == '0);

	// Neighbor nodes of the current one
	assign up_lvl = lvl_q - LW'(1);
	assign up_pos = pos_q >> 1;
	assign dn_lvl = lvl_q + LW'(1);
	assign dn_pos = (pos_q << 1) | LEVELS'(!alu_ge);

	// Geometry of the leaf on accept, else of the parent on the climb
	assign geo_lvl = (state_q == bpa_pkg::ST_IDLE) ? LW'(LEVELS) : up_lvl;
	assign geo_pos = (state_q == bpa_pkg::ST_IDLE) ? leaf_pos : up_pos;
	assign geo_len = usable_len(geo_lvl, geo_pos);

	// Block offset: the block ends at the node's end
	assign off_calc = node_start(lvl_q, pos_q) + (PAGE_G >> lvl_q) - GW'(rd_val);

	// Operands of the shared unit by state
	always_comb begin
		alu_op   = (kind_q == bpa_pkg::KIND_FREE) ? bpa_pkg::ALU_MERGE : bpa_pkg::ALU_MAX;
		alu_full = W'(geo_len);
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				alu_a = W'(root_q);
				alu_b = W'(req_size);
			end
			bpa_pkg::ST_UP: begin
				alu_a = W'(cur_q);
				alu_b = W'(rd_val);
			end
			default: begin
				alu_a = W'(rd_val);
				alu_b = req_q;
			end
		endcase
	end

	bpa_node_alu #(
		.W(W)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.full (alu_full),
		.ge   (alu_ge),
		.res  (alu_res)
	);

	assign up_val = alu_res[VAL_W-1:0];

	// Decide whether an accepted item walks the tree
	assign alloc_go = (kind == bpa_pkg::KIND_ALLOC) && (req_size != '0) && fits && alu_ge;
	assign free_go  = (kind == bpa_pkg::KIND_FREE) && !off_past && (geo_len != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (alloc_go) begin
						state_d = (tl_calc == '0) ? bpa_pkg::ST_TGT : bpa_pkg::ST_DESC;
					end else if (free_go) begin
						state_d = bpa_pkg::ST_CLIMB;
					end else begin
						state_d = bpa_pkg::ST_DONE;
					end
				end
			end
			bpa_pkg::ST_DESC: begin
				state_d = (dn_lvl == tl_q) ? bpa_pkg::ST_TGT : bpa_pkg::ST_DESC;
			end
			bpa_pkg::ST_TGT: begin
				if (!alu_ge || lvl_q == '0) begin
					state_d = bpa_pkg::ST_DONE;
				end else begin
					state_d = bpa_pkg::ST_UP;
				end
			end
			bpa_pkg::ST_CLIMB: begin
				if (lvl_q == '0) begin
					state_d = bpa_pkg::ST_DONE;
				end else begin
					state_d = rd_zero ? bpa_pkg::ST_UP : bpa_pkg::ST_CLIMB;
				end
			end
			bpa_pkg::ST_UP: begin
				state_d = (up_lvl == '0) ? bpa_pkg::ST_DONE : bpa_pkg::ST_UP;
			end
			bpa_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath and memory control per state
	always_comb begin
		kind_d    = kind_q;
		req_d     = req_q;
		tl_d      = tl_q;
		lvl_d     = lvl_q;
		pos_d     = pos_q;
		cur_d     = cur_q;
		root_d    = root_q;
		res_ok_d  = res_ok_q;
		res_off_d = res_off_q;
		rd_lvl_d  = rd_lvl_q;
		rd_pos_d  = rd_pos_q;
		mem_ctl   = '0;
		wr_addr   = '0;
		wr_data   = '0;
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				if (in_acc) begin
					kind_d    = kind;
					req_d     = W'(req_size);
					tl_d      = tl_calc;
					res_ok_d  = 1'b0;
					res_off_d = '0;
					lvl_d     = '0;
					pos_d     = '0;
					if (alloc_go) begin
						// Read the root itself or its left child
						mem_ctl.rd_en = 1'b1;
						rd_lvl_d      = (tl_calc == '0) ? LW'(0) : LW'(1);
						rd_pos_d      = '0;
					end else if (free_go) begin
						// Start the climb at the leaf
						mem_ctl.rd_en = 1'b1;
						lvl_d         = LW'(LEVELS);
						pos_d         = leaf_pos;
						rd_lvl_d      = LW'(LEVELS);
						rd_pos_d      = leaf_pos;
					end
				end
			end
			bpa_pkg::ST_DESC: begin
				// Step to the left child if it fits, else to the right
				lvl_d         = dn_lvl;
				pos_d         = dn_pos;
				mem_ctl.rd_en = 1'b1;
				if (dn_lvl == tl_q) begin
					rd_lvl_d = dn_lvl;
					rd_pos_d = dn_pos;
				end else begin
					rd_lvl_d = dn_lvl + LW'(1);
					rd_pos_d = dn_pos << 1;
				end
			end
			bpa_pkg::ST_TGT: begin
				// If the node fits, claim it and start the update climb
				if (alu_ge) begin
					res_ok_d      = 1'b1;
					res_off_d     = off_calc[bpa_pkg::FIELD_W-1:0];
					mem_ctl.wr_en = 1'b1;
					wr_addr       = node_idx(lvl_q, pos_q);
					wr_data       = '0;
					cur_d         = '0;
					if (lvl_q == '0) begin
						root_d = '0;
					end else begin
						mem_ctl.rd_en = 1'b1;
						rd_lvl_d      = lvl_q;
						rd_pos_d      = pos_q ^ LEVELS'(1);
					end
				end
			end
			bpa_pkg::ST_CLIMB: begin
				if (!rd_zero) begin
					// Advance to the parent until an allocated node shows up
					if (lvl_q != '0) begin
						lvl_d         = up_lvl;
						pos_d         = up_pos;
						mem_ctl.rd_en = 1'b1;
						rd_lvl_d      = up_lvl;
						rd_pos_d      = up_pos;
					end
				end else begin
					// Restore the node and start merging upward
					res_ok_d      = 1'b1;
					mem_ctl.wr_en = 1'b1;
					wr_addr       = node_idx(lvl_q, pos_q);
					wr_data       = rd_usable;
					cur_d         = rd_usable;
					if (lvl_q == '0) begin
						root_d = rd_usable;
					end else begin
						mem_ctl.rd_en = 1'b1;
						rd_lvl_d      = lvl_q;
						rd_pos_d      = pos_q ^ LEVELS'(1);
					end
				end
			end
			bpa_pkg::ST_UP: begin
				// Refresh the parent from both children, fetch the next buddy
				mem_ctl.wr_en = 1'b1;
				wr_addr       = node_idx(up_lvl, up_pos);
				wr_data       = up_val;
				cur_d         = up_val;
				lvl_d         = up_lvl;
				pos_d         = up_pos;
				if (up_lvl == '0) begin
					root_d = up_val;
				end else begin
					mem_ctl.rd_en = 1'b1;
					rd_lvl_d      = up_lvl;
					rd_pos_d      = up_pos ^ LEVELS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = node_idx(rd_lvl_d, rd_pos_d);

	bpa_tree_mem #(
		.DEPTH (NODE_COUNT),
		.AW    (IW),
		.DW    (VAL_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (mem_rd_data),
		.rd_hit  (mem_rd_hit)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::ST_IDLE;
			root_q      <= ROOT_USABLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			root_q  <= root_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers and result word
	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		req_q     <= req_d;
		tl_q      <= tl_d;
		lvl_q     <= lvl_d;
		pos_q     <= pos_d;
		cur_q     <= cur_d;
		res_ok_q  <= res_ok_d;
		res_off_q <= res_off_d;
		rd_lvl_q  <= rd_lvl_d;
		rd_pos_q  <= rd_pos_d;
		if (out_load) begin
			ok_q           <= res_ok_q;
			block_offset_q <= res_off_q;
			page_empty_q   <= (root_q == ROOT_USABLE);
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign block_offset = block_offset_q;
	assign page_empty   = page_empty_q;

	// An accepted word always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != bpa_pkg::ST_IDLE))
		else $error("accepted word did not start the sequencer");

	// The walk never reads the node it is writing
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_addr != rd_addr))
		else $error("tree memory read and write hit the same node");

	// The root run never exceeds the usable page
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_q <= ROOT_USABLE)
		else $error("root run exceeds usable page length");

	// A result is loaded only on the way out of the last state
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == bpa_pkg::ST_IDLE) && out_valid_q)
		else $error("result load did not return to idle with a valid word");

endmodule

[design/bpa_node_alu.sv]
// ----------------------------------------------------------------------------
// bpa_node_alu
// Shared compare and update unit for tree nodes. Compares a against b and
// forms the new parent run: the larger child or, for a merge, the whole node
// when both children together cover it.
// ----------------------------------------------------------------------------
module bpa_node_alu #(
	parameter int unsigned W = 13
) (
	input  bpa_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  logic [W-1:0]     full,
	output logic             ge,
	output logic [W-1:0]     res
);

	logic [W:0]   sum;
	logic [W-1:0] big;

	// Compare, pick the larger run, check for a buddy merge
	always_comb begin
		ge  = (a >= b);
		big = ge ? a : b;
		sum = {1'b0, a} + {1'b0, b};
		case (op)
			bpa_pkg::ALU_MAX:   res = big;
			bpa_pkg::ALU_MERGE: res = (sum == {1'b0, full}) ? full : big;
			default:            res = big;
		endcase
	end

endmodule

[design/bpa_tree_mem.sv]
// ----------------------------------------------------------------------------
// bpa_tree_mem
// Node memory of the longest-free tree: one write and one registered read
// per cycle. A valid bit per node marks entries written since reset; the
// read returns it with the data so the caller can supply the initial length.
// ----------------------------------------------------------------------------
module bpa_tree_mem #(
	parameter int unsigned DEPTH = 255,
	parameter int unsigned AW    = 8,
	parameter int unsigned DW    = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [DW-1:0]      wr_data,
	input  logic [AW-1:0]      rd_addr,
	output logic [DW-1:0]      rd_data,
	output logic               rd_hit
);

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_data_q;
	logic             rd_hit_q;

	// Write the node array, register the read word
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Track written entries, register the hit flag with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule
